[design/ssd_pkg.sv]
// Shared types, codes and segment tables for the decimal seven-segment serializer.
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned NUM_BITS    = 16;
  localparam int unsigned SEG_BITS    = 16;
  localparam int unsigned DIGIT_BITS  = 4;
  localparam int unsigned BIT_IDX_W   = $clog2(WORD_BITS);

  localparam logic [NUM_BITS-1:0] DIV10_MUL   = 16'hCCCD;
  localparam int unsigned         DIV10_SHIFT = 19;

  localparam logic OP_NUMBER = 1'b0;
  localparam logic OP_RAW    = 1'b1;

  localparam logic [1:0] DIGIT_UNITS    = 2'd0;
  localparam logic [1:0] DIGIT_TENS     = 2'd1;
  localparam logic [1:0] DIGIT_HUNDREDS = 2'd2;

  typedef struct packed {
    logic                 opcode;
    logic [NUM_BITS-1:0]  number;
    logic [WORD_BITS-1:0] raw_word;
  } in_req_t;

  typedef struct packed {
    logic serial_bit;
    logic latch_after;
  } out_req_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_CONV,
    FR_PUSH
  } fr_state_e;

  function automatic logic [SEG_BITS-1:0] outer_seg(input logic [DIGIT_BITS-1:0] d);
    logic [SEG_BITS-1:0] p;
    unique case (d)
      4'd0:    p = 16'h7007;
      4'd1:    p = 16'h4001;
      4'd2:    p = 16'h300B;
      4'd3:    p = 16'h600B;
      4'd4:    p = 16'h400D;
      4'd5:    p = 16'h600E;
      4'd6:    p = 16'h700E;
      4'd7:    p = 16'h4003;
      4'd8:    p = 16'h700F;
      4'd9:    p = 16'h600F;
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic logic [SEG_BITS-1:0] middle_seg(input logic [DIGIT_BITS-1:0] d);
    logic [SEG_BITS-1:0] p;
    unique case (d)
      4'd0:    p = 16'h0770;
      4'd1:    p = 16'h0410;
      4'd2:    p = 16'h03B0;
      4'd3:    p = 16'h06B0;
      4'd4:    p = 16'h04D0;
      4'd5:    p = 16'h06E0;
      4'd6:    p = 16'h07E0;
      4'd7:    p = 16'h0430;
      4'd8:    p = 16'h07F0;
      4'd9:    p = 16'h06F0;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

[design/ssd_front.sv]
// Front end: accepts requests and builds the segment word, one decimal digit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module ssd_front (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire ssd_pkg::in_req_t                 in_req_i,
  output logic                                  push_valid_o,
  output logic [ssd_pkg::WORD_BITS-1:0]         push_word_o,
  input  wire logic                             push_full_i
);

  ssd_pkg::fr_state_e                   state_q, state_d;
  logic [1:0]                           digit_q, digit_d;
  logic [ssd_pkg::NUM_BITS-1:0]         val_q, val_d;
  logic [ssd_pkg::WORD_BITS-1:0]        word_q, word_d;

  logic [2*ssd_pkg::NUM_BITS-1:0]       prod;
  logic [ssd_pkg::NUM_BITS-1:0]         quot;
  logic [ssd_pkg::NUM_BITS-1:0]         rem;
  logic [ssd_pkg::DIGIT_BITS-1:0]       digit;
  logic                                 accept;

  assign prod  = val_q * ssd_pkg::DIV10_MUL;
  assign quot  = ssd_pkg::NUM_BITS'(prod >> ssd_pkg::DIV10_SHIFT);
  assign rem   = val_q - ((quot << 3) + (quot << 1));
  assign digit = rem[ssd_pkg::DIGIT_BITS-1:0];

  assign in_stall_o   = (state_q != ssd_pkg::FR_IDLE);
  assign accept       = in_valid_i && !in_stall_o;
  assign push_valid_o = (state_q == ssd_pkg::FR_PUSH);
  assign push_word_o  = word_q;

  always_comb begin
    state_d = state_q;
    digit_d = digit_q;
    val_d   = val_q;
    word_d  = word_q;
    unique case (state_q)
      ssd_pkg::FR_IDLE: begin
        if (accept) begin
          if (in_req_i.opcode == ssd_pkg::OP_RAW) begin
            word_d  = in_req_i.raw_word;
            state_d = ssd_pkg::FR_PUSH;
          end else begin
            word_d  = '0;
            val_d   = in_req_i.number;
            digit_d = ssd_pkg::DIGIT_UNITS;
            state_d = ssd_pkg::FR_CONV;
          end
        end
      end
      ssd_pkg::FR_CONV: begin
        val_d   = quot;
        digit_d = digit_q + 2'd1;
        unique case (digit_q)
          ssd_pkg::DIGIT_UNITS: begin
            word_d = word_q | {{ssd_pkg::SEG_BITS{1'b0}}, ssd_pkg::outer_seg(digit)};
          end
          ssd_pkg::DIGIT_TENS: begin
            word_d = word_q | {{ssd_pkg::SEG_BITS{1'b0}}, ssd_pkg::middle_seg(digit)};
          end
          ssd_pkg::DIGIT_HUNDREDS: begin
            word_d  = word_q | {ssd_pkg::outer_seg(digit), {ssd_pkg::SEG_BITS{1'b0}}};
            state_d = ssd_pkg::FR_PUSH;
          end
          default: begin
            state_d = ssd_pkg::FR_IDLE;
          end
        endcase
      end
      ssd_pkg::FR_PUSH: begin
        if (!push_full_i) begin
          state_d = ssd_pkg::FR_IDLE;
        end
      end
      default: begin
        state_d = ssd_pkg::FR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssd_pkg::FR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
    val_q   <= val_d;
    word_q  <= word_d;
  end

  a_push_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid_o && push_full_i) |=> (push_valid_o && $stable(push_word_o)))
    else $error("front dropped a word while the queue was full");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ssd_pkg::FR_CONV) |=> !$past(accept))
    else $error("front took a request while converting");

endmodule

`default_nettype wire

[design/ssd_queue.sv]
// Short queue of segment words between front end and shifter.
`timescale 1ns / 1ps
`default_nettype none

module ssd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_valid_i,
  input  wire logic [ssd_pkg::WORD_BITS-1:0] push_word_i,
  output logic                               full_o,
  output logic                               pop_valid_o,
  output logic [ssd_pkg::WORD_BITS-1:0]      pop_word_o,
  input  wire logic                          pop_ready_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [ssd_pkg::WORD_BITS-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]              wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]              cnt_q;
  logic                          do_push, do_pop;

  assign full_o      = (cnt_q == FULL_CNT);
  assign pop_valid_o = (cnt_q != '0);
  assign pop_word_o  = mem_q[rd_ptr_q];
  assign do_push     = push_valid_i && !full_o;
  assign do_pop      = pop_ready_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL_CNT)
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

[design/ssd_shifter.sv]
// Back end: shifts each segment word out LSB first and flags its last bit.
`timescale 1ns / 1ps
`default_nettype none

module ssd_shifter (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          pop_valid_i,
  input  wire logic [ssd_pkg::WORD_BITS-1:0] pop_word_i,
  output logic                               pop_ready_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output ssd_pkg::out_req_t                  out_req_o
);

  localparam logic [ssd_pkg::BIT_IDX_W-1:0] LAST_BIT =
    ssd_pkg::BIT_IDX_W'(ssd_pkg::WORD_BITS - 1);

  logic                              busy_q;
  logic [ssd_pkg::BIT_IDX_W-1:0]     bit_q;
  logic [ssd_pkg::WORD_BITS-1:0]     word_q;
  logic                              accept, last;

  assign accept      = busy_q && !out_stall_i;
  assign last        = (bit_q == LAST_BIT);
  assign pop_ready_o = !busy_q || (accept && last);
  assign out_valid_o = busy_q;

  always_comb begin
    out_req_o.serial_bit  = word_q[0];
    out_req_o.latch_after = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      if (pop_ready_o && pop_valid_i) begin
        busy_q <= 1'b1;
        bit_q  <= '0;
      end else if (accept) begin
        if (last) begin
          busy_q <= 1'b0;
        end else begin
          bit_q <= bit_q + ssd_pkg::BIT_IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_ready_o && pop_valid_i) begin
      word_q <= pop_word_i;
    end else if (accept) begin
      word_q <= word_q >> 1;
    end
  end

  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last && !pop_valid_i) |=> !out_valid_o)
    else $error("shifter kept going past the last bit");

  a_next_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last && pop_valid_i) |=> (out_valid_o && bit_q == '0))
    else $error("shifter did not start the next word");

endmodule

`default_nettype wire

[design/decimal_seven_segment_serializer.sv]
// Top level of the decimal seven-segment serializer.
// Each request yields one 32-bit segment word, sent as 32 results, one serial bit per
// cycle when not stalled, LSB first, latch_after set on the last. A decimal request shows
// the last three digits of number (hundreds wrap above 999); a raw request sends raw_word
// unchanged. Sustained throughput is set by the one-bit-per-cycle output shifter.
// The front end converts a number units, tens then hundreds with a single divide-by-ten
// multiplier and then offers the word to the queue from its push state. It takes no new
// request until that word is in the queue. The queue of QUEUE_DEPTH words lets it take
// new requests while the shifter is still sending.
`timescale 1ns / 1ps
`default_nettype none

module decimal_seven_segment_serializer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ssd_pkg::in_req_t  in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output ssd_pkg::out_req_t      out_req_o
);

  logic                          push_valid, full;
  logic [ssd_pkg::WORD_BITS-1:0] push_word, pop_word;
  logic                          pop_valid, pop_ready;

  ssd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_req_i     (in_req_i),
    .push_valid_o (push_valid),
    .push_word_o  (push_word),
    .push_full_i  (full)
  );

  ssd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_word_i  (push_word),
    .full_o       (full),
    .pop_valid_o  (pop_valid),
    .pop_word_o   (pop_word),
    .pop_ready_i  (pop_ready)
  );

  ssd_shifter u_shifter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_word_i  (pop_word),
    .pop_ready_o (pop_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the decimal seven-segment serializer: predicts each segment word.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned HALF_PERIOD  = 6;
  localparam int unsigned RESET_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned HOLD_ITEMS   = 8;
  localparam int unsigned PHASE_ITEMS  = 27;
  localparam int unsigned LIMIT_NS     = 3_000_000;

  localparam logic [ssd_pkg::SEG_BITS-1:0] OUTER_PATTERN [10] = '{
    16'h7007, 16'h4001, 16'h300B, 16'h600B, 16'h400D,
    16'h600E, 16'h700E, 16'h4003, 16'h700F, 16'h600F
  };
  localparam logic [ssd_pkg::SEG_BITS-1:0] MIDDLE_PATTERN [10] = '{
    16'h0770, 16'h0410, 16'h03B0, 16'h06B0, 16'h04D0,
    16'h06E0, 16'h07E0, 16'h0430, 16'h07F0, 16'h06F0
  };

  typedef struct packed {
    logic                          typed;
    logic [ssd_pkg::WORD_BITS-1:0] word;
    ssd_pkg::in_req_t              req;
  } directed_row_t;

  localparam int unsigned DIRECTED_ROWS = 19;
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    {1'b1, 32'h7007_7777, ssd_pkg::OP_NUMBER, 16'd0,     32'h0000_0000},
    {1'b1, 32'h700F_77FF, ssd_pkg::OP_NUMBER, 16'd888,   32'h0000_0000},
    {1'b1, 32'h7007_7777, ssd_pkg::OP_NUMBER, 16'd1000,  32'hFFFF_FFFF},
    {1'b1, 32'h0000_0000, ssd_pkg::OP_RAW,    16'd0,     32'h0000_0000},
    {1'b1, 32'hFFFF_FFFF, ssd_pkg::OP_RAW,    16'hFFFF,  32'hFFFF_FFFF},
    {1'b1, 32'h8000_0001, ssd_pkg::OP_RAW,    16'd0,     32'h8000_0001},
    {1'b1, 32'hA5A5_5A5A, ssd_pkg::OP_RAW,    16'd1234,  32'hA5A5_5A5A},
    {1'b0, 32'h0000_0000, ssd_pkg::OP_NUMBER, 16'd111,   32'h0000_0000},
    {1'b0, 32'h0000_0000, ssd_pkg::OP_NUMBER, 16'd222,   32'h5555_5555},
    {1'b0, 32'h0000_0000, ssd_pkg::OP_NUMBER, 16'd333,   32'h0000_0000},
    {1'b0, 32'h0000_0000, ssd_pkg::OP_NUMBER, 16'd444,   32'hAAAA_AAAA},
    {1'b0, 32'h0000_0000, ssd_pkg::OP_NUMBER, 16'd555,   32'h0000_0000},
    {1'b0, 32'h0000_0000, ssd_pkg::OP_NUMBER, 16'd666,   32'h0000_0000},
    {1'b0, 32'h0000_0000, ssd_pkg::OP_NUMBER, 16'd777,   32'h0000_0000},
    {1'b0, 32'h0000_0000, ssd_pkg::OP_NUMBER, 16'd999,   32'h0000_0000},
    {1'b0, 32'h0000_0000, ssd_pkg::OP_NUMBER, 16'd65535, 32'h0000_0000},
    {1'b0, 32'h0000_0000, ssd_pkg::OP_NUMBER, 16'd1234,  32'h0000_0000},
    {1'b0, 32'h0000_0000, ssd_pkg::OP_NUMBER, 16'd12345, 32'hFFFF_FFFF},
    {1'b0, 32'h0000_0000, ssd_pkg::OP_NUMBER, 16'd507,   32'h0000_0000}
  };

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  ssd_pkg::in_req_t  in_req_i    = '0;
  logic              out_stall_i = 1'b1;
  logic              in_stall_o;
  logic              out_valid_o;
  ssd_pkg::out_req_t out_req_o;

  logic        hold_req  = 1'b0;
  int unsigned hold_left = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned err_count = 0;

  logic [ssd_pkg::WORD_BITS-1:0] pending_words [$];
  ssd_pkg::out_req_t             expected_bits [$];

  decimal_seven_segment_serializer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  initial begin
    #LIMIT_NS;
    $display("tb: errors");
    $finish;
  end

  function automatic logic [ssd_pkg::WORD_BITS-1:0] segment_word(input ssd_pkg::in_req_t req);
    int unsigned hundreds;
    int unsigned tens;
    int unsigned units;
    hundreds = (int'(req.number) / 100) % 10;
    tens     = (int'(req.number) / 10) % 10;
    units    = int'(req.number) % 10;
    if (req.opcode == ssd_pkg::OP_RAW) begin
      return req.raw_word;
    end
    return {OUTER_PATTERN[hundreds], 16'h0000} | {16'h0000, MIDDLE_PATTERN[tens]} |
           {16'h0000, OUTER_PATTERN[units]};
  endfunction

  function automatic ssd_pkg::in_req_t random_request();
    ssd_pkg::in_req_t req;
    req.opcode   = ($urandom_range(3) == 0) ? ssd_pkg::OP_RAW : ssd_pkg::OP_NUMBER;
    req.number   = $urandom_range(1) ? 16'($urandom_range(999)) : 16'($urandom_range(65535));
    req.raw_word = $urandom;
    return req;
  endfunction

  task automatic report_mismatch(input string what);
    $display("tb: mismatch at %0t: %s", $realtime, what);
    err_count++;
  endtask

  task automatic send_request(input ssd_pkg::in_req_t req,
                              input logic [ssd_pkg::WORD_BITS-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    pending_words.push_back(word);
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_random(input int unsigned count);
    ssd_pkg::in_req_t req;
    repeat (count) begin
      req = random_request();
      send_request(req, segment_word(req));
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : track
    logic [ssd_pkg::WORD_BITS-1:0] word;
    ssd_pkg::out_req_t             want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (pending_words.size() == 0) begin
          report_mismatch("request accepted with no word queued");
        end else begin
          word = pending_words.pop_front();
          for (int i = 0; i < ssd_pkg::WORD_BITS; i++) begin
            want.serial_bit  = word[i];
            want.latch_after = (i == ssd_pkg::WORD_BITS - 1);
            expected_bits.push_back(want);
          end
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_bits.size() == 0) begin
          report_mismatch("unexpected result");
        end else begin
          want = expected_bits.pop_front();
          if (out_req_o.serial_bit !== want.serial_bit) begin
            report_mismatch($sformatf("serial_bit %b, want %b",
                                      out_req_o.serial_bit, want.serial_bit));
          end
          if (out_req_o.latch_after !== want.latch_after) begin
            report_mismatch($sformatf("latch_after %b, want %b",
                                      out_req_o.latch_after, want.latch_after));
          end
        end
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      send_request(DIRECTED[i].req,
                   DIRECTED[i].typed ? DIRECTED[i].word : segment_word(DIRECTED[i].req));
    end

    send_idle_pct = 37;
    recv_idle_pct = 51;
    send_random(PHASE_ITEMS);

    send_idle_pct = 51;
    recv_idle_pct = 37;
    send_random(PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    send_random(HOLD_ITEMS);
    send_random(PHASE_ITEMS - HOLD_ITEMS);

    in_valid_i <= 1'b0;
    while (pending_words.size() != 0 || expected_bits.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
